// File: rtl/core/brf_pkg.sv
// Package for the circular byte FIFO: sizes, command codes and transaction types.
// Used by brf_bank, brf_merge and byte_ring_fifo. No dependencies.
`default_nettype none

package brf_pkg;

    // LANES must be a power of two and divide CAPACITY.
    localparam int CAPACITY    = 1024;
    localparam int LANES       = 8;
    localparam int BYTE_FIELDS = 8;
    localparam int LANE_LIMIT  = (LANES < BYTE_FIELDS) ? LANES : BYTE_FIELDS;

    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int CNT_W  = 11;
    localparam int LANE_W = $clog2(LANES);
    localparam int ROWS   = CAPACITY / LANES;
    localparam int ROW_W  = IDX_W - LANE_W;

    typedef enum logic [1:0] {
        CMD_PUSH        = 2'd0,
        CMD_GET         = 2'd1,
        CMD_GET_PARTIAL = 2'd2,
        CMD_CLEAR       = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd       cmd;
        logic [3:0] byte_count;
        logic [7:0] in_byte0;
        logic [7:0] in_byte1;
        logic [7:0] in_byte2;
        logic [7:0] in_byte3;
        logic [7:0] in_byte4;
        logic [7:0] in_byte5;
        logic [7:0] in_byte6;
        logic [7:0] in_byte7;
    } t_in;

    typedef struct packed {
        logic             success;
        logic [3:0]       read_count;
        logic [7:0]       out_byte0;
        logic [7:0]       out_byte1;
        logic [7:0]       out_byte2;
        logic [7:0]       out_byte3;
        logic [7:0]       out_byte4;
        logic [7:0]       out_byte5;
        logic [7:0]       out_byte6;
        logic [7:0]       out_byte7;
        logic [CNT_W-1:0] fill_level;
        logic [CNT_W-1:0] free_space;
    } t_out;

    // Result information carried alongside the bank read
    typedef struct packed {
        logic              success;
        logic [3:0]        read_count;
        logic [LANE_W-1:0] start_lane;
        logic [CNT_W-1:0]  fill_level;
        logic [CNT_W-1:0]  free_space;
    } t_meta;

endpackage

`default_nettype wire

// File: rtl/core/byte_ring_fifo.sv
// Top level of the circular byte FIFO: command decode, pointer control,
// lane banks and output register. Depends on brf_pkg, brf_bank, brf_merge.
`default_nettype none

// Usage:
// Input channel i_in (i_in_valid / o_in_stall) carries one command per
// transaction: push, strict get, partial get or clear, with up to eight bytes.
// Output channel o_out (o_out_valid / i_out_stall) returns exactly one result
// per command: success, bytes read oldest first, fill level and free space.
// The command decode and the lane memory read fill the read stage; the lane
// merge then fills the output register that drives o_out_valid. One command
// is taken every cycle while o_in_stall is low; the limit is the single
// read and write port of each byte lane, every lane serving one byte.
// While the receiver stalls, one result waits in the output register and one
// more in the read stage; only then is o_in_stall raised.
// Synchronous reset empties the FIFO (pointers and fill to zero) and drops
// any result in flight; the stored bytes are not cleared.
module byte_ring_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire brf_pkg::t_in  i_in,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output brf_pkg::t_out      o_out
);

    localparam int IDX_W  = brf_pkg::IDX_W;
    localparam int CNT_W  = brf_pkg::CNT_W;
    localparam int LANE_W = brf_pkg::LANE_W;
    localparam int LANES  = brf_pkg::LANES;

    logic [IDX_W-1:0] r_rd_idx, n_rd_idx;
    logic [IDX_W-1:0] r_wr_idx, n_wr_idx;
    logic [CNT_W-1:0] r_count,  n_count;

    logic             r_s1_valid;
    brf_pkg::t_meta   r_s1_meta, n_meta;
    logic             r_out_valid;
    brf_pkg::t_out    r_out;
    brf_pkg::t_out    merged;

    logic accept, adv_out;
    logic push_ok;
    logic [3:0] nread;
    logic [CNT_W-1:0] cnt_ext, free_now;

    logic [LANES-1:0][7:0] lane_q;
    logic [brf_pkg::BYTE_FIELDS-1:0][7:0] in_bytes;

    function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
                                                  input logic [3:0] step);
        logic [IDX_W:0] sum;
        sum = {1'b0, base} + (IDX_W+1)'(step);
        if (sum >= (IDX_W+1)'(brf_pkg::CAPACITY)) begin
            sum = sum - (IDX_W+1)'(brf_pkg::CAPACITY);
        end
        return sum[IDX_W-1:0];
    endfunction

    assign adv_out    = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !adv_out;
    assign accept     = i_in_valid && !o_in_stall;

    assign in_bytes = {i_in.in_byte7, i_in.in_byte6, i_in.in_byte5, i_in.in_byte4,
                       i_in.in_byte3, i_in.in_byte2, i_in.in_byte1, i_in.in_byte0};

    assign cnt_ext  = CNT_W'(i_in.byte_count);
    assign free_now = CNT_W'(brf_pkg::CAPACITY) - r_count;
    assign push_ok  = (i_in.byte_count <= 4'(brf_pkg::LANE_LIMIT)) && (cnt_ext <= free_now);

    // Command decode: outcome, bytes to read and next pointer state
    always_comb begin
        logic [3:0] req;
        logic       ok;
        ok       = 1'b0;
        nread    = 4'd0;
        req      = 4'd0;
        n_rd_idx = r_rd_idx;
        n_wr_idx = r_wr_idx;
        n_count  = r_count;
        unique case (i_in.cmd)
            brf_pkg::CMD_PUSH: begin
                if (push_ok) begin
                    ok       = 1'b1;
                    n_wr_idx = wrap_add(r_wr_idx, i_in.byte_count);
                    n_count  = r_count + cnt_ext;
                end
            end
            brf_pkg::CMD_GET: begin
                if (i_in.byte_count == 4'd0) begin
                    ok = 1'b1;
                end else if (i_in.byte_count <= 4'(brf_pkg::LANE_LIMIT)
                             && cnt_ext <= r_count) begin
                    ok    = 1'b1;
                    nread = i_in.byte_count;
                end
            end
            brf_pkg::CMD_GET_PARTIAL: begin
                req = (i_in.byte_count < 4'(brf_pkg::LANE_LIMIT)) ?
                      i_in.byte_count : 4'(brf_pkg::LANE_LIMIT);
                nread = (r_count < CNT_W'(req)) ? r_count[3:0] : req;
                ok    = (nread != 4'd0);
            end
            brf_pkg::CMD_CLEAR: begin
                ok       = 1'b1;
                n_rd_idx = '0;
                n_wr_idx = '0;
                n_count  = '0;
            end
            default: ;
        endcase
        if (nread != 4'd0) begin
            n_rd_idx = wrap_add(r_rd_idx, nread);
            n_count  = r_count - CNT_W'(nread);
        end
        n_meta.success    = ok;
        n_meta.read_count = nread;
        n_meta.start_lane = r_rd_idx[LANE_W-1:0];
        n_meta.fill_level = n_count;
        n_meta.free_space = CNT_W'(brf_pkg::CAPACITY) - n_count;
    end

    // Byte lanes: lane b holds every address whose low bits equal b
    for (genvar b = 0; b < LANES; b++) begin : g_lane
        logic [LANE_W-1:0] wr_off, rd_off;
        logic [IDX_W-1:0]  wr_addr, rd_addr;
        logic              we;

        assign wr_off  = LANE_W'(b) - r_wr_idx[LANE_W-1:0];
        assign rd_off  = LANE_W'(b) - r_rd_idx[LANE_W-1:0];
        assign wr_addr = wrap_add(r_wr_idx, 4'(wr_off));
        assign rd_addr = wrap_add(r_rd_idx, 4'(rd_off));
        assign we      = accept && (i_in.cmd == brf_pkg::CMD_PUSH) && push_ok
                         && (4'(wr_off) < i_in.byte_count);

        brf_bank u_bank (
            .i_clk     (i_clk),
            .i_we      (we),
            .i_wr_row  (wr_addr[IDX_W-1:LANE_W]),
            .i_wr_data (in_bytes[wr_off]),
            .i_re      (accept),
            .i_rd_row  (rd_addr[IDX_W-1:LANE_W]),
            .o_rd_data (lane_q[b])
        );
    end

    brf_merge u_merge (
        .i_meta      (r_s1_meta),
        .i_lane_data (lane_q),
        .o_result    (merged)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx    <= '0;
            r_wr_idx    <= '0;
            r_count     <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_rd_idx  <= n_rd_idx;
                r_wr_idx  <= n_wr_idx;
                r_count   <= n_count;
                r_s1_meta <= n_meta;
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (adv_out) begin
                r_s1_valid <= 1'b0;
            end
            if (adv_out) begin
                r_out_valid <= 1'b1;
                r_out       <= merged;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

// File: rtl/core/brf_bank.sv
// One byte lane of the FIFO store: holds every LANES-th byte address.
// Depends on brf_pkg for sizes.
`default_nettype none

module brf_bank (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [brf_pkg::ROW_W-1:0] i_wr_row,
    input  wire logic [7:0]               i_wr_data,
    input  wire logic                     i_re,
    input  wire logic [brf_pkg::ROW_W-1:0] i_rd_row,
    output logic      [7:0]               o_rd_data
);

    logic [7:0] mem [brf_pkg::ROWS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_wr_row] <= i_wr_data;
        end
        if (i_re) begin
            o_rd_data <= mem[i_rd_row];
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/brf_merge.sv
// Merge stage: rotates the lane read data into oldest-first order and
// blanks bytes beyond the read count. Depends on brf_pkg.
`default_nettype none

module brf_merge (
    input  wire brf_pkg::t_meta                   i_meta,
    input  wire logic [brf_pkg::LANES-1:0][7:0]   i_lane_data,
    output brf_pkg::t_out                         o_result
);

    logic [brf_pkg::BYTE_FIELDS-1:0][7:0] bytes;

    always_comb begin
        logic [brf_pkg::LANE_W-1:0] lane;
        for (int k = 0; k < brf_pkg::BYTE_FIELDS; k++) begin
            lane = i_meta.start_lane + brf_pkg::LANE_W'(k);
            if (4'(k) < i_meta.read_count) begin
                bytes[k] = i_lane_data[lane];
            end else begin
                bytes[k] = 8'd0;
            end
        end
    end

    always_comb begin
        o_result.success    = i_meta.success;
        o_result.read_count = i_meta.read_count;
        o_result.out_byte0  = bytes[0];
        o_result.out_byte1  = bytes[1];
        o_result.out_byte2  = bytes[2];
        o_result.out_byte3  = bytes[3];
        o_result.out_byte4  = bytes[4];
        o_result.out_byte5  = bytes[5];
        o_result.out_byte6  = bytes[6];
        o_result.out_byte7  = bytes[7];
        o_result.fill_level = i_meta.fill_level;
        o_result.free_space = i_meta.free_space;
    end

endmodule

`default_nettype wire

// File: verif/tb_top.sv
// Self-checking bench for byte_ring_fifo: directed and random command transactions,
// each result checked against an in-bench model of the ring FIFO.
// Depends on brf_pkg and byte_ring_fifo.

module tb_top;

    localparam int IDLE_PCT       = 15;
    localparam int QUIET_FROM     = 300;   // no idling on either side in this cycle window
    localparam int QUIET_TO       = 600;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int MAX_REPORTS    = 50;

    logic          i_clk       = 1'b0;
    logic          i_rst_n     = 1'b0;
    logic          i_in_valid  = 1'b0;
    logic          o_in_stall;
    brf_pkg::t_in  i_in        = '0;
    logic          o_out_valid;
    logic          i_out_stall = 1'b0;
    brf_pkg::t_out o_out;

    brf_pkg::t_in  cmd_queue[$];
    brf_pkg::t_out awaited_results[$];
    int unsigned   error_count  = 0;
    int unsigned   cycle_no     = 0;
    int unsigned   stuck_cycles = 0;

    // Shadow copy of the FIFO
    logic [7:0]                shadow_bytes [brf_pkg::CAPACITY];
    logic [brf_pkg::IDX_W-1:0] shadow_rd    = '0;
    logic [brf_pkg::IDX_W-1:0] shadow_wr    = '0;
    int                        shadow_level = 0;

    byte_ring_fifo dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [brf_pkg::IDX_W-1:0] ring_next(
        logic [brf_pkg::IDX_W-1:0] idx);
        return (idx == brf_pkg::IDX_W'(brf_pkg::CAPACITY - 1)) ? '0 : idx + 1'b1;
    endfunction

    // Applies one command to the shadow FIFO and returns the result it should give
    function automatic brf_pkg::t_out predict_fifo_result(brf_pkg::t_in item);
        logic [7:0]    lane_in  [brf_pkg::BYTE_FIELDS];
        logic [7:0]    lane_out [brf_pkg::BYTE_FIELDS];
        int            count;
        int            nread;
        logic          ok;
        brf_pkg::t_out res;
        lane_in = '{item.in_byte0, item.in_byte1, item.in_byte2, item.in_byte3,
                    item.in_byte4, item.in_byte5, item.in_byte6, item.in_byte7};
        foreach (lane_out[k]) lane_out[k] = '0;
        count = int'(item.byte_count);
        nread = 0;
        ok    = 1'b0;
        case (item.cmd)
            brf_pkg::CMD_PUSH: begin
                // all or nothing
                if (count <= brf_pkg::LANE_LIMIT
                    && count <= brf_pkg::CAPACITY - shadow_level) begin
                    for (int k = 0; k < count; k++) begin
                        shadow_bytes[shadow_wr] = lane_in[k];
                        shadow_wr = ring_next(shadow_wr);
                    end
                    shadow_level += count;
                    ok = 1'b1;
                end
            end
            brf_pkg::CMD_GET: begin
                if (count == 0) begin
                    ok = 1'b1;
                end else if (count <= brf_pkg::LANE_LIMIT && count <= shadow_level) begin
                    nread = count;
                    ok    = 1'b1;
                end
            end
            brf_pkg::CMD_GET_PARTIAL: begin
                nread = (count < brf_pkg::LANE_LIMIT) ? count : brf_pkg::LANE_LIMIT;
                if (shadow_level < nread) nread = shadow_level;
                ok = (nread != 0);
            end
            default: begin
                // clear keeps the stored bytes
                shadow_rd    = '0;
                shadow_wr    = '0;
                shadow_level = 0;
                ok           = 1'b1;
            end
        endcase
        for (int k = 0; k < nread; k++) begin
            lane_out[k] = shadow_bytes[shadow_rd];
            shadow_rd = ring_next(shadow_rd);
        end
        shadow_level -= nread;
        res.success    = ok;
        res.read_count = 4'(nread);
        res.out_byte0  = lane_out[0];
        res.out_byte1  = lane_out[1];
        res.out_byte2  = lane_out[2];
        res.out_byte3  = lane_out[3];
        res.out_byte4  = lane_out[4];
        res.out_byte5  = lane_out[5];
        res.out_byte6  = lane_out[6];
        res.out_byte7  = lane_out[7];
        res.fill_level = brf_pkg::CNT_W'(shadow_level);
        res.free_space = brf_pkg::CNT_W'(brf_pkg::CAPACITY - shadow_level);
        return res;
    endfunction

    // Random payload bytes unless a fixed value is asked for
    function automatic brf_pkg::t_in make_cmd(brf_pkg::t_cmd op, int count,
                                              int fixed_byte = -1);
        brf_pkg::t_in item;
        item.cmd        = op;
        item.byte_count = 4'(count);
        {item.in_byte0, item.in_byte1, item.in_byte2, item.in_byte3,
         item.in_byte4, item.in_byte5, item.in_byte6, item.in_byte7} = {$urandom, $urandom};
        if (fixed_byte >= 0)
            {item.in_byte0, item.in_byte1, item.in_byte2, item.in_byte3,
             item.in_byte4, item.in_byte5, item.in_byte6, item.in_byte7} =
                {brf_pkg::BYTE_FIELDS{8'(fixed_byte)}};
        return item;
    endfunction

    function automatic brf_pkg::t_cmd random_op();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 40) return brf_pkg::CMD_PUSH;
        if (pick < 65) return brf_pkg::CMD_GET;
        if (pick < 95) return brf_pkg::CMD_GET_PARTIAL;
        return brf_pkg::CMD_CLEAR;
    endfunction

    function automatic bit take_break();
        return (cycle_no < QUIET_FROM || cycle_no >= QUIET_TO) &&
               ($urandom_range(99) < IDLE_PCT);
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            if (error_count < MAX_REPORTS)
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            error_count++;
        end
    endtask

    initial begin
        // empty FIFO corner cases
        cmd_queue.push_back(make_cmd(brf_pkg::CMD_GET, 1));
        cmd_queue.push_back(make_cmd(brf_pkg::CMD_GET_PARTIAL, 8));
        cmd_queue.push_back(make_cmd(brf_pkg::CMD_GET_PARTIAL, 0));
        cmd_queue.push_back(make_cmd(brf_pkg::CMD_GET, 0));
        cmd_queue.push_back(make_cmd(brf_pkg::CMD_PUSH, 0));
        cmd_queue.push_back(make_cmd(brf_pkg::CMD_PUSH, 3));
        cmd_queue.push_back(make_cmd(brf_pkg::CMD_GET, 3));
        // counts above the lane limit
        cmd_queue.push_back(make_cmd(brf_pkg::CMD_PUSH, 9));
        cmd_queue.push_back(make_cmd(brf_pkg::CMD_PUSH, 15));
        cmd_queue.push_back(make_cmd(brf_pkg::CMD_PUSH, 8, 8'hFF));
        cmd_queue.push_back(make_cmd(brf_pkg::CMD_PUSH, 8, 8'h00));
        cmd_queue.push_back(make_cmd(brf_pkg::CMD_GET, 9));
        cmd_queue.push_back(make_cmd(brf_pkg::CMD_GET, 15));
        cmd_queue.push_back(make_cmd(brf_pkg::CMD_GET_PARTIAL, 15));
        cmd_queue.push_back(make_cmd(brf_pkg::CMD_GET_PARTIAL, 0));
        cmd_queue.push_back(make_cmd(brf_pkg::CMD_GET, 5));
        cmd_queue.push_back(make_cmd(brf_pkg::CMD_GET_PARTIAL, 8));
        cmd_queue.push_back(make_cmd(brf_pkg::CMD_GET, 4));
        cmd_queue.push_back(make_cmd(brf_pkg::CMD_PUSH, 7));
        cmd_queue.push_back(make_cmd(brf_pkg::CMD_CLEAR, 15));
        cmd_queue.push_back(make_cmd(brf_pkg::CMD_GET, 1));
        cmd_queue.push_back(make_cmd(brf_pkg::CMD_PUSH, 8));
        cmd_queue.push_back(make_cmd(brf_pkg::CMD_GET, 8));
        // leave the pointers off a lane boundary before filling
        cmd_queue.push_back(make_cmd(brf_pkg::CMD_PUSH, 5));
        cmd_queue.push_back(make_cmd(brf_pkg::CMD_GET, 5));

        // fill toward full, mostly with eight-byte pushes
        repeat (132)
            cmd_queue.push_back(make_cmd(brf_pkg::CMD_PUSH,
                ($urandom_range(9) == 0) ? $urandom_range(8) : 8));
        // drain with strict and partial gets
        repeat (140)
            cmd_queue.push_back(($urandom_range(9) < 7) ?
                make_cmd(brf_pkg::CMD_GET, $urandom_range(8, 1)) :
                make_cmd(brf_pkg::CMD_GET_PARTIAL, $urandom_range(15, 1)));
        repeat (150) cmd_queue.push_back(make_cmd(random_op(), $urandom_range(15)));
        repeat (100) cmd_queue.push_back(make_cmd(brf_pkg::CMD_PUSH, 8));
        repeat (110) cmd_queue.push_back(make_cmd(random_op(), $urandom_range(15)));

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(negedge i_clk);
        while (cmd_queue.size() != 0 || i_in_valid || awaited_results.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Command driver; the expected result is worked out when the transaction is taken
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                awaited_results.push_back(predict_fifo_result(i_in));
            if (!i_in_valid || !o_in_stall) begin
                if (cmd_queue.size() != 0 && !take_break()) begin
                    i_in       <= cmd_queue.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor
    always @(posedge i_clk) begin : result_mon
        brf_pkg::t_out want;
        if (i_rst_n) begin
            i_out_stall <= take_break();
            if (o_out_valid && !i_out_stall) begin
                if (awaited_results.size() == 0) begin
                    if (error_count < MAX_REPORTS)
                        $error("result transaction with no command outstanding");
                    error_count++;
                end else begin
                    want = awaited_results.pop_front();
                    check_field("success",    want.success,    o_out.success);
                    check_field("read_count", want.read_count, o_out.read_count);
                    check_field("out_byte0",  want.out_byte0,  o_out.out_byte0);
                    check_field("out_byte1",  want.out_byte1,  o_out.out_byte1);
                    check_field("out_byte2",  want.out_byte2,  o_out.out_byte2);
                    check_field("out_byte3",  want.out_byte3,  o_out.out_byte3);
                    check_field("out_byte4",  want.out_byte4,  o_out.out_byte4);
                    check_field("out_byte5",  want.out_byte5,  o_out.out_byte5);
                    check_field("out_byte6",  want.out_byte6,  o_out.out_byte6);
                    check_field("out_byte7",  want.out_byte7,  o_out.out_byte7);
                    check_field("fill_level", want.fill_level, o_out.fill_level);
                    check_field("free_space", want.free_space, o_out.free_space);
                end
            end
        end
    end

    // Watchdog: too long without any transaction on either side
    always @(posedge i_clk) begin
        cycle_no <= cycle_no + 1;
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles == WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

endmodule
